>>> rtl/core/afbt_pkg.sv
// ----------------------------------------------------------------------------
// afbt_pkg
// Shared types, constants and the backoff table for the authentication
// failure backoff throttle.
// ----------------------------------------------------------------------------
package afbt_pkg;

   // slot table geometry: one entry per user slot plus the shared slot
   localparam int SLOTS      = 16;
   localparam int ENTRIES    = SLOTS + 1;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int SLOT_W     = 4;
   localparam int NOW_W      = 48;
   localparam int UNTIL_W    = 49;
   localparam int RETRY_W    = 27;
   localparam int COUNT_W    = 8;
   localparam int DECISION_W = 3;

   localparam logic [IDX_W-1:0]   SHARED_IDX  = IDX_W'(SLOTS);
   localparam logic [RETRY_W-1:0] RETRY_MAX   = {RETRY_W{1'b1}};
   localparam logic [RETRY_W-1:0] MAX_BACKOFF_RESET = RETRY_W'(30000);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hff;

   // backoff steps by failure count
   localparam logic [RETRY_W-1:0] BACKOFF_1 = RETRY_W'(250);
   localparam logic [RETRY_W-1:0] BACKOFF_2 = RETRY_W'(500);
   localparam logic [RETRY_W-1:0] BACKOFF_3 = RETRY_W'(1000);
   localparam logic [RETRY_W-1:0] BACKOFF_4 = RETRY_W'(2000);
   localparam logic [RETRY_W-1:0] BACKOFF_5 = RETRY_W'(5000);
   localparam logic [RETRY_W-1:0] BACKOFF_6 = RETRY_W'(10000);

   typedef enum logic [1:0] {
      OP_ATTEMPT   = 2'd0,
      OP_CLEAR_ONE = 2'd1,
      OP_CLEAR_ALL = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_ALLOWED     = 2'd0,
      VERDICT_BAD_CRED    = 2'd1,
      VERDICT_ROLE_DENIED = 2'd2,
      VERDICT_UNKNOWN     = 2'd3
   } verdict_type;

   localparam logic [DECISION_W-1:0] DECISION_RATE_LIMITED = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic evaluate;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip_eval;
   } status_type;

   // backoff for a given failure count
   function automatic logic [RETRY_W-1:0] backoff_for(input logic [COUNT_W-1:0] count,
                                                      input logic [RETRY_W-1:0] max_ms);
      logic [RETRY_W-1:0] result;
      case (count)
         8'd0:    result = '0;
         8'd1:    result = BACKOFF_1;
         8'd2:    result = BACKOFF_2;
         8'd3:    result = BACKOFF_3;
         8'd4:    result = BACKOFF_4;
         8'd5:    result = BACKOFF_5;
         8'd6:    result = BACKOFF_6;
         default: result = max_ms;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/core/afbt_ctrl.sv
// ----------------------------------------------------------------------------
// afbt_ctrl
// Sequencer for the throttle: accepts a word, then steps the datapath
// through table lookup, evaluation and commit; other operations skip the read and evaluation.
// ----------------------------------------------------------------------------
module afbt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  afbt_pkg::status_type status,
   output afbt_pkg::cmd_type    cmd
);
   import afbt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            // clears need no table read or evaluation
            if (status.skip_eval) state_in = ST_COMMIT;
            else                  state_in = ST_EVAL;
         end
         ST_EVAL:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_LOOKUP: cmd.lookup   = ~status.skip_eval;
         ST_EVAL:   cmd.evaluate = 1'b1;
         ST_COMMIT: cmd.commit   = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

endmodule

>>> rtl/core/afbt_datapath.sv
// ----------------------------------------------------------------------------
// afbt_datapath
// Slot table, backoff register and the evaluate/commit arithmetic of the
// throttle, driven by commands from the controller.
// ----------------------------------------------------------------------------
module afbt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  afbt_pkg::cmd_type                 cmd,
   output afbt_pkg::status_type              status,
   input  logic [1:0]                        req_operation,
   input  logic [afbt_pkg::SLOT_W-1:0]       req_slot,
   input  logic                              req_known,
   input  logic [1:0]                        req_verdict,
   input  logic [afbt_pkg::NOW_W-1:0]        req_now_ms,
   input  logic                              csr_wr_en,
   input  logic [afbt_pkg::RETRY_W-1:0]      csr_wr_data,
   output logic                              rsp_valid,
   output logic [afbt_pkg::DECISION_W-1:0]   rsp_decision,
   output logic [afbt_pkg::RETRY_W-1:0]      rsp_retry_after_ms,
   output logic [afbt_pkg::COUNT_W-1:0]      rsp_failure_count
);
   import afbt_pkg::*;

   // slot table
   logic [COUNT_W-1:0] count_ff [ENTRIES];
   logic [UNTIL_W-1:0] until_ff [ENTRIES];

   // configuration
   logic [RETRY_W-1:0] max_backoff_ff;

   // captured word
   op_type             op_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic [1:0]         verdict_ff;
   logic [NOW_W-1:0]   now_ff;

   // entry read
   logic [COUNT_W-1:0] entry_cnt_ff;
   logic [UNTIL_W-1:0] entry_until_ff;

   // evaluation results
   logic               blocked_ff;
   logic               blocked_in;
   logic [RETRY_W-1:0] wait_ff;
   logic [RETRY_W-1:0] wait_in;
   logic [COUNT_W-1:0] new_cnt_ff;
   logic [COUNT_W-1:0] new_cnt_in;
   logic [RETRY_W-1:0] backoff_ff;
   logic               pass_clear;
   logic [UNTIL_W-1:0] diff;
   logic [UNTIL_W-1:0] new_until;

   // response
   logic                  rsp_valid_ff;
   logic [DECISION_W-1:0] rsp_decision_ff;
   logic [RETRY_W-1:0]    rsp_retry_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // slot select: unknown actors and out-of-range slots use the shared entry
   always_comb begin
      if (req_known && (int'(req_slot) < SLOTS)) idx_in = IDX_W'(req_slot);
      else                                        idx_in = SHARED_IDX;
   end

   assign status.skip_eval = (op_ff != OP_ATTEMPT);

   // backoff register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_backoff_ff <= MAX_BACKOFF_RESET;
      end else if (csr_wr_en) begin
         max_backoff_ff <= csr_wr_data;
      end
   end

   // capture the word
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_UNUSED;
      end else if (cmd.capture) begin
         op_ff <= op_type'(req_operation);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff     <= idx_in;
         verdict_ff <= req_verdict;
         now_ff     <= req_now_ms;
      end
   end

   // read the selected entry
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         entry_cnt_ff   <= count_ff[idx_ff];
         entry_until_ff <= until_ff[idx_ff];
      end
   end

   // blocked test, remaining wait and next count
   always_comb begin
      diff       = entry_until_ff - {1'b0, now_ff};
      blocked_in = entry_until_ff > {1'b0, now_ff};
      if (diff > UNTIL_W'(RETRY_MAX)) wait_in = RETRY_MAX;
      else                            wait_in = diff[RETRY_W-1:0];
      pass_clear = (verdict_ff == VERDICT_ALLOWED) || (verdict_ff == VERDICT_ROLE_DENIED);
      if (pass_clear)                     new_cnt_in = '0;
      else if (entry_cnt_ff == COUNT_MAX) new_cnt_in = COUNT_MAX;
      else                                new_cnt_in = entry_cnt_ff + COUNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         blocked_ff <= blocked_in;
         wait_ff    <= wait_in;
         new_cnt_ff <= new_cnt_in;
         backoff_ff <= backoff_for(new_cnt_in, max_backoff_ff);
      end
   end

   // new block deadline
   assign new_until = {1'b0, now_ff} + UNTIL_W'(backoff_ff);

   // table update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            count_ff[i] <= '0;
            until_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         case (op_ff)
            OP_CLEAR_ONE: begin
               count_ff[idx_ff] <= '0;
               until_ff[idx_ff] <= '0;
            end
            OP_CLEAR_ALL: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  count_ff[i] <= '0;
                  until_ff[i] <= '0;
               end
            end
            OP_ATTEMPT: begin
               if (!blocked_ff) begin
                  count_ff[idx_ff] <= new_cnt_ff;
                  if (pass_clear) until_ff[idx_ff] <= '0;
                  else            until_ff[idx_ff] <= new_until;
               end
            end
            default: ;
         endcase
      end
   end

   // response strobe, one cycle per attempt
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit && (op_ff == OP_ATTEMPT);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (blocked_ff) begin
            rsp_decision_ff <= DECISION_RATE_LIMITED;
            rsp_retry_ff    <= wait_ff;
            rsp_count_ff    <= entry_cnt_ff;
         end else begin
            rsp_decision_ff <= DECISION_W'(verdict_ff);
            rsp_retry_ff    <= '0;
            rsp_count_ff    <= new_cnt_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decision       = rsp_decision_ff;
   assign rsp_retry_after_ms = rsp_retry_ff;
   assign rsp_failure_count  = rsp_count_ff;

endmodule

>>> rtl/core/auth_failure_backoff_throttle.sv
// ----------------------------------------------------------------------------
// auth_failure_backoff_throttle
// Per-user authentication throttle with a saturating failure count and
// tabled backoff per slot.
// ----------------------------------------------------------------------------
// An attempt is taken when start is high and busy is low and occupies the
// block from the accept cycle on through a read of the slot table, the
// blocked test and backoff selection, and the table write. Its word appears
// on the rsp_ ports for one cycle, marked by rsp_valid, in the cycle busy
// falls; it cannot be held off and must be taken then. Clear operations and
// the unused operation code skip the read and the test and give no word.
// The backoff register may be written only while busy is low.
module auth_failure_backoff_throttle (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic [afbt_pkg::SLOT_W-1:0]       req_slot,
   input  logic                              req_known,
   input  logic [1:0]                        req_verdict,
   input  logic [afbt_pkg::NOW_W-1:0]        req_now_ms,
   input  logic                              csr_wr_en,
   input  logic [afbt_pkg::RETRY_W-1:0]      csr_wr_data,
   output logic                              rsp_valid,
   output logic [afbt_pkg::DECISION_W-1:0]   rsp_decision,
   output logic [afbt_pkg::RETRY_W-1:0]      rsp_retry_after_ms,
   output logic [afbt_pkg::COUNT_W-1:0]      rsp_failure_count
);
   import afbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   afbt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // slot table and arithmetic
   afbt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_known          (req_known),
      .req_verdict        (req_verdict),
      .req_now_ms         (req_now_ms),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_decision       (rsp_decision),
      .rsp_retry_after_ms (rsp_retry_after_ms),
      .rsp_failure_count  (rsp_failure_count)
   );

endmodule

>>> rtl/core/afbt_checker.sv
// ----------------------------------------------------------------------------
// afbt_checker
// Port-level checks on the throttle's handshake and result words.
// ----------------------------------------------------------------------------
module afbt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [afbt_pkg::DECISION_W-1:0]   rsp_decision,
   input logic [afbt_pkg::RETRY_W-1:0]      rsp_retry_after_ms
);
   import afbt_pkg::*;

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // a result shows only as the block goes idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // results are single-cycle strobes
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // only a rate-limited answer carries a wait
   a_retry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_decision != DECISION_RATE_LIMITED) |-> rsp_retry_after_ms == '0)
      else $error("nonzero wait on a pass-through answer");

   // decision code in range
   a_decision_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_decision <= DECISION_RATE_LIMITED)
      else $error("decision code out of range");

endmodule

bind auth_failure_backoff_throttle afbt_checker u_afbt_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_decision       (rsp_decision),
   .rsp_retry_after_ms (rsp_retry_after_ms)
);
